// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on clk_i and held off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RCL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define RCL_ASSERT_NEXT(label, ante, cons, msg) \
  `RCL_ASSERT(label, (ante) |=> (cons), msg)

`endif

// File: rtl/rcl_pkg.sv
// ---------------------------------------------------------------------------
// rcl_pkg
// Shared types, constants and helpers of the resource colour lookup.
// ---------------------------------------------------------------------------
package rcl_pkg;

  localparam int KEY_MAX_DEF = 8;
  localparam int CHAR_W      = 8;
  localparam int KEY_TEXT_W  = 64;
  localparam int KEY_LEN_W   = 4;
  localparam int NUM_DIGITS  = 6;
  localparam int DIGITS_W    = NUM_DIGITS * CHAR_W;
  localparam int DCNT_W      = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = KEY_TEXT_W;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_TEXT   = 1'b0,
    CFG_KEY_LENGTH = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_KEY,
    PH_TAB,
    PH_HASH,
    PH_DIGITS,
    PH_SKIP
  } phase_e;

  // Control handed to every cell of the key chain.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // Status reported by every cell.
  typedef struct packed {
    logic hit;
    logic sep;
  } cell_stat_t;

  function automatic logic is_hex(input logic [CHAR_W-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

endpackage

// File: rtl/rcl_if.sv
// ---------------------------------------------------------------------------
// rcl_in_if / rcl_out_if
// Valid/ready channels for text words and result words.
// ---------------------------------------------------------------------------
interface rcl_in_if;
  import rcl_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_byte;
  logic              end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface rcl_out_if;
  import rcl_pkg::*;

  logic                valid;
  logic                ready;
  logic                found;
  logic [DIGITS_W-1:0] colour_digits;

  modport source (output valid, output found, output colour_digits, input ready);
  modport sink   (input valid, input found, input colour_digits, output ready);
endinterface

// File: rtl/rcl_cell.sv
// ---------------------------------------------------------------------------
// rcl_cell
// One stage of the key chain: holds a recent key-region character, passes
// it on when the chain shifts and compares it with its key character.
// ---------------------------------------------------------------------------
module rcl_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rcl_pkg::cell_ctrl_t       ctrl_i,
  input  logic [rcl_pkg::CHAR_W-1:0] char_i,
  input  logic [rcl_pkg::CHAR_W-1:0] key_char_i,
  input  logic                      active_i,
  output logic [rcl_pkg::CHAR_W-1:0] char_o,
  output rcl_pkg::cell_stat_t       stat_o
);
  import rcl_pkg::*;

  logic [CHAR_W-1:0] char_q, char_d;

  always_comb begin
    char_d = char_q;
    if (ctrl_i.clear) begin
      char_d = CH_NUL;
    end else if (ctrl_i.shift) begin
      char_d = char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= CH_NUL;
    end else begin
      char_q <= char_d;
    end
  end

  assign char_o     = char_q;
  // Cells beyond the key length always agree.
  assign stat_o.hit = !active_i || (char_q == key_char_i);
  assign stat_o.sep = (char_q == CH_STAR) || (char_q == CH_DOT);

endmodule

// File: rtl/resource_colour_lookup.sv
// Result: the result word is registered and presented in the cycle after the word
//   marked end_of_text is accepted; other words give no result.
// Throughput: one text word per cycle while no held result stalls the input;
//   the key chain shifts one character per cycle; keys compare in the colon's cycle.
// Reset: clears the key registers, the chain and all scan state.
// ---------------------------------------------------------------------------
// resource_colour_lookup
// Streams a resource text and captures the six hex digits of the colour
// value on the first line whose key before the colon matches the
// configured key.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module resource_colour_lookup #(
  parameter int KEY_MAX = rcl_pkg::KEY_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rcl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rcl_in_if.sink                        in_i,
  rcl_out_if.source                     out_o
);
  import rcl_pkg::*;

  localparam int DEPTH = KEY_MAX + 1;        // key cells plus the separator cell
  localparam int KLW   = $clog2(DEPTH);      // holds 0..KEY_MAX
  localparam int LCW   = $clog2(DEPTH + 1);  // holds 0..DEPTH

  // ---------------- configuration registers ----------------
  logic [KEY_TEXT_W-1:0] key_q;
  logic [KEY_LEN_W-1:0]  key_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      key_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_TEXT:   key_q     <= cfg_data_i;
        CFG_KEY_LENGTH: key_len_q <= cfg_data_i[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the key length to KEY_MAX, the number of key cells.
  logic [KLW-1:0] klen;
  assign klen = (key_len_q > KEY_LEN_W'(KEY_MAX)) ? KLW'(KEY_MAX) : KLW'(key_len_q);

  // ---------------- handshake ----------------
  logic                out_v_q;
  logic                found_q;
  logic [DIGITS_W-1:0] digits_q;
  logic                in_fire;
  logic [CHAR_W-1:0]   c;

  // Accept a word whenever the output register is empty or drains this cycle.
  assign in_i.ready = !out_v_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign c          = in_i.text_byte;

  // ---------------- scan state ----------------
  phase_e              phase_q, phase_d;
  logic [LCW-1:0]      line_cnt_q, line_cnt_d;
  logic [DCNT_W-1:0]   dcnt_q, dcnt_d;
  logic [DIGITS_W-1:0] cap_q, cap_d;
  logic                match_q, match_d;
  logic                ended_q, ended_d;
  logic                key_ok;
  logic                live;
  logic                shift;
  logic                clear;

  // A word only counts while no match is held and no zero byte has been seen.
  assign live  = in_fire && !match_q && !ended_q;
  // Advance the key chain on every key-region character except the colon.
  assign shift = live && (c != CH_NUL) && (c != CH_NL) && (phase_q == PH_KEY) &&
                 (c != CH_COLON);
  // Drop all scan state once the last word of a text is taken.
  assign clear = in_fire && in_i.end_of_text;

  // ---------------- key chain ----------------
  logic [CHAR_W-1:0] chain [DEPTH+1];
  cell_stat_t        stat  [DEPTH];
  logic [DEPTH-1:0]  hit_vec;
  logic [DEPTH-1:0]  sep_vec;
  cell_ctrl_t        ctrl;

  assign ctrl.shift = shift;
  assign ctrl.clear = clear;
  assign chain[0]   = c;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [CHAR_W-1:0] key_char;
    logic              active;

    // Cell i holds the i-th newest character, which lines up with key
    // character klen-1-i.
    always_comb begin
      key_char = '0;
      for (int j = 0; j < KEY_MAX; j++) begin
        if ((i + j + 1) == int'(klen)) begin
          key_char = key_q[CHAR_W*j +: CHAR_W];
        end
      end
    end
    assign active = i < int'(klen);

    rcl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .char_i     (chain[i]),
      .key_char_i (key_char),
      .active_i   (active),
      .char_o     (chain[i+1]),
      .stat_o     (stat[i])
    );

    assign hit_vec[i] = stat[i].hit;
    assign sep_vec[i] = stat[i].sep;
  end

  // Key must fill the region exactly, or be preceded by '*' or '.'.
  assign key_ok = &hit_vec && (line_cnt_q >= LCW'(klen)) &&
                  ((line_cnt_q == LCW'(klen)) || sep_vec[klen]);

  // ---------------- phase machine ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_KEY;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    line_cnt_d = line_cnt_q;
    dcnt_d     = dcnt_q;
    cap_d      = cap_q;
    match_d    = match_q;
    ended_d    = ended_q;
    if (live) begin
      if (c == CH_NUL) begin
        ended_d = 1'b1;
      end else if (c == CH_NL) begin
        line_cnt_d = '0;
        phase_d    = PH_KEY;
        dcnt_d     = '0;
      end else begin
        unique case (phase_q)
          PH_KEY: begin
            if (c == CH_COLON) begin
              phase_d = key_ok ? PH_TAB : PH_SKIP;
            end else if (line_cnt_q < LCW'(DEPTH)) begin
              line_cnt_d = line_cnt_q + LCW'(1);
            end
          end
          PH_TAB: begin
            phase_d = (c == CH_TAB) ? PH_HASH : PH_SKIP;
          end
          PH_HASH: begin
            if (c == CH_HASH) begin
              phase_d = PH_DIGITS;
              dcnt_d  = '0;
              cap_d   = '0;
            end else begin
              phase_d = PH_SKIP;
            end
          end
          PH_DIGITS: begin
            if (!is_hex(c)) begin
              phase_d = PH_SKIP;
            end else begin
              for (int k = 0; k < NUM_DIGITS; k++) begin
                if (dcnt_q == DCNT_W'(k)) begin
                  cap_d[CHAR_W*k +: CHAR_W] = c;
                end
              end
              dcnt_d = dcnt_q + DCNT_W'(1);
              if (dcnt_d >= DCNT_W'(NUM_DIGITS)) begin
                match_d = 1'b1;
                phase_d = PH_SKIP;
              end
            end
          end
          PH_SKIP: ;
          default: phase_d = PH_SKIP;
        endcase
      end
    end
    // Return to the reset state after the last word of a text.
    if (clear) begin
      phase_d    = PH_KEY;
      line_cnt_d = '0;
      dcnt_d     = '0;
      cap_d      = '0;
      match_d    = 1'b0;
      ended_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_cnt_q <= '0;
      dcnt_q     <= '0;
      cap_q      <= '0;
      match_q    <= 1'b0;
      ended_q    <= 1'b0;
    end else begin
      line_cnt_q <= line_cnt_d;
      dcnt_q     <= dcnt_d;
      cap_q      <= cap_d;
      match_q    <= match_d;
      ended_q    <= ended_d;
    end
  end

  // ---------------- result register ----------------
  // The result reflects the state after the last word, before the clear.
  logic                res_found;
  logic [DIGITS_W-1:0] res_digits;

  always_comb begin
    res_found  = match_q;
    res_digits = cap_q;
    if (live && phase_q == PH_DIGITS && c != CH_NUL && c != CH_NL && is_hex(c) &&
        (dcnt_q + DCNT_W'(1)) >= DCNT_W'(NUM_DIGITS)) begin
      res_found  = 1'b1;
      res_digits = cap_q;
      for (int k = 0; k < NUM_DIGITS; k++) begin
        if (dcnt_q == DCNT_W'(k)) begin
          res_digits[CHAR_W*k +: CHAR_W] = c;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      found_q <= 1'b0;
    end else if (clear) begin
      out_v_q <= 1'b1;
      found_q <= res_found;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear) begin
      digits_q <= res_found ? res_digits : '0;
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.found         = found_q;
  assign out_o.colour_digits = digits_q;

  // ---------------- assertions ----------------
  `RCL_ASSERT(a_nofound_zero, (out_v_q && !found_q) |-> (digits_q == '0),
              "result without a match carries digits")
  `RCL_ASSERT(a_match_skips, match_q |-> (phase_q == PH_SKIP),
              "match held outside the skip phase")
  `RCL_ASSERT(a_dcnt_range, dcnt_q <= DCNT_W'(NUM_DIGITS),
              "digit count beyond six")
  `RCL_ASSERT_NEXT(a_clear_all, clear,
                   (line_cnt_q == '0) && !match_q && !ended_q && (chain[DEPTH] == '0),
                   "scan state not cleared after end of text")

endmodule

// File: test/tb.sv
// ---------------------------------------------------------------------------
// tb: resource colour lookup testbench
// Streams resource texts word by word into the block, models the key and
// colour scan on the side and compares every result word with the colour
// that the model found for the same text. Covers directed lines, key
// extremes, a long output stall and random texts under several keys.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcl_pkg::*;

  typedef logic [CHAR_W-1:0] text_t [$];

  typedef struct {
    logic                found;
    logic [DIGITS_W-1:0] digits;
  } colour_result_t;

  localparam int    IDLE_PCT   = 37;
  localparam int    HOLD_LEN   = 80;
  localparam int    PHASE_WORDS = 55;
  localparam string HEX_SET    = "0123456789ABCDEFabcdef";

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rcl_in_if  in_if ();
  rcl_out_if out_if ();

  resource_colour_lookup i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  // Register copies as the block sees them.
  logic [KEY_TEXT_W-1:0] key_chars;
  logic [KEY_LEN_W-1:0]  key_len;

  // Scan state of the colour search.
  logic [CHAR_W-1:0]   seen_chars [0:KEY_MAX_DEF];
  int                  line_len;
  phase_e              scan_phase;
  int                  digit_cnt;
  logic [DIGITS_W-1:0] colour_acc;
  logic                line_matched;
  logic                text_stopped;

  colour_result_t pending_colours [$];
  int             mismatches;
  int             words_sent;
  bit             tx_idle_en;
  bit             rx_idle_en;
  int             rx_hold_req;

  // -------------------------------------------------------------------------
  // Colour search model
  // -------------------------------------------------------------------------
  function automatic void clear_scan();
    foreach (seen_chars[i]) seen_chars[i] = '0;
    line_len     = 0;
    scan_phase   = PH_KEY;
    digit_cnt    = 0;
    colour_acc   = '0;
    line_matched = 1'b0;
    text_stopped = 1'b0;
  endfunction

  function automatic int key_span();
    return (key_len > KEY_MAX_DEF) ? KEY_MAX_DEF : int'(key_len);
  endfunction

  function automatic logic hex_digit(input logic [CHAR_W-1:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  // Key sits right before the colon and starts the line or follows '*'/'.'.
  function automatic logic key_fits();
    int span;
    span = key_span();
    if (line_len < span) return 1'b0;
    for (int j = 0; j < span; j++) begin
      if (seen_chars[span-1-j] != key_chars[CHAR_W*j +: CHAR_W]) return 1'b0;
    end
    if (line_len == span) return 1'b1;
    return seen_chars[span] == CH_STAR || seen_chars[span] == CH_DOT;
  endfunction

  function automatic void scan_char(input logic [CHAR_W-1:0] c);
    if (line_matched || text_stopped) return;
    if (c == CH_NUL) begin
      text_stopped = 1'b1;
      return;
    end
    if (c == CH_NL) begin
      line_len   = 0;
      scan_phase = PH_KEY;
      digit_cnt  = 0;
      return;
    end
    case (scan_phase)
      PH_KEY: begin
        if (c == CH_COLON) begin
          scan_phase = key_fits() ? PH_TAB : PH_SKIP;
        end else begin
          for (int i = KEY_MAX_DEF; i > 0; i--) seen_chars[i] = seen_chars[i-1];
          seen_chars[0] = c;
          if (line_len < KEY_MAX_DEF + 1) line_len++;
        end
      end
      PH_TAB:  scan_phase = (c == CH_TAB) ? PH_HASH : PH_SKIP;
      PH_HASH: begin
        if (c == CH_HASH) begin
          scan_phase = PH_DIGITS;
          digit_cnt  = 0;
          colour_acc = '0;
        end else begin
          scan_phase = PH_SKIP;
        end
      end
      PH_DIGITS: begin
        if (!hex_digit(c)) begin
          scan_phase = PH_SKIP;
        end else begin
          colour_acc[CHAR_W*digit_cnt +: CHAR_W] = c;
          digit_cnt++;
          if (digit_cnt >= NUM_DIGITS) begin
            line_matched = 1'b1;
            scan_phase   = PH_SKIP;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Advance the model by one accepted word; the last word of a text yields
  // the colour that the block must report.
  function automatic void predict_word(input logic [CHAR_W-1:0] c, input logic last);
    colour_result_t r;
    scan_char(c);
    if (last) begin
      r.found  = line_matched;
      r.digits = line_matched ? colour_acc : '0;
      pending_colours.push_back(r);
      clear_scan();
    end
  endfunction

  // -------------------------------------------------------------------------
  // Clock, limit and result checking
  // -------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, exp_v, act_v);
  endtask

  // Check every result word against the oldest expected colour, then pick
  // the next ready: hold off for a requested stretch, else idle at random.
  initial begin : result_monitor
    colour_result_t exp_r;
    int             hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (pending_colours.size() == 0) begin
          flag_mismatch("unexpected result", '0,
                        64'({out_if.found, out_if.colour_digits}));
        end else begin
          exp_r = pending_colours.pop_front();
          if (out_if.found !== exp_r.found)
            flag_mismatch("found", 64'(exp_r.found), 64'(out_if.found));
          if (out_if.colour_digits !== exp_r.digits)
            flag_mismatch("colour_digits", 64'(exp_r.digits), 64'(out_if.colour_digits));
        end
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (rx_hold_req > 0) begin
        out_if.ready <= 1'b0;
        hold_left   = rx_hold_req - 1;
        rx_hold_req = 0;
      end else begin
        out_if.ready <= rst_ni && !(rx_idle_en && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------
  // Offer one text word, idling at random first, and hold it until taken.
  task automatic send_word(input logic [CHAR_W-1:0] c, input logic last);
    while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.text_byte   <= c;
    in_if.end_of_text <= last;
    do @(posedge clk_i); while (!in_if.ready);
    predict_word(c, last);
    words_sent++;
  endtask

  task automatic send_text(input text_t t);
    foreach (t[i]) send_word(t[i], i == t.size() - 1);
  endtask

  task automatic push_str(ref text_t t, input string s);
    foreach (s[i]) t.push_back(s[i]);
  endtask

  task automatic add_key(ref text_t t);
    for (int j = 0; j < key_span(); j++) t.push_back(key_chars[CHAR_W*j +: CHAR_W]);
  endtask

  task automatic send_str(input string s);
    text_t t;
    push_str(t, s);
    send_text(t);
  endtask

  // Drop valid and let every expected word come out, plus the result latency.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_colours.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_KEY_TEXT) key_chars = data;
    else key_len = data[KEY_LEN_W-1:0];
  endtask

  task automatic set_key(input logic [KEY_TEXT_W-1:0] text, input int len);
    wait_idle();
    write_reg(CFG_KEY_TEXT, text);
    write_reg(CFG_KEY_LENGTH, CFG_DATA_W'(len));
  endtask

  function automatic logic [CHAR_W-1:0] rand_hex();
    return HEX_SET[$urandom_range(HEX_SET.len() - 1)];
  endfunction

  // Key characters that can match: anything but zero, newline and colon.
  function automatic logic [CHAR_W-1:0] rand_key_char();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(1, 255)); while (c == CH_NL || c == CH_COLON);
    return c;
  endfunction

  // Append one line: mostly well formed with the current key, else a line
  // with one flaw, else raw noise.
  task automatic build_line(ref text_t t);
    text_t             k;
    int                kind;
    int                flaw;
    int                ndig;
    logic [CHAR_W-1:0] c;
    add_key(k);
    kind = $urandom_range(99);
    if (kind >= 85) begin
      repeat ($urandom_range(1, 12))
        t.push_back(($urandom_range(19) == 0) ? CH_NUL : CHAR_W'($urandom_range(1, 255)));
      t.push_back(CH_NL);
      return;
    end
    flaw = (kind >= 60) ? $urandom_range(7) : -1;
    if (flaw < 0) begin
      case ($urandom_range(4))
        1: t.push_back(CH_STAR);
        2: t.push_back(CH_DOT);
        3: begin
          repeat ($urandom_range(1, 3)) t.push_back(CHAR_W'($urandom_range(97, 122)));
          t.push_back(CH_DOT);
        end
        4: begin
          repeat ($urandom_range(1, 3)) t.push_back(CHAR_W'($urandom_range(97, 122)));
          t.push_back(CH_STAR);
        end
        default: ;
      endcase
    end
    if (flaw == 0) t.push_back("x");
    if (flaw == 5 && k.size() > 0) k[$urandom_range(k.size() - 1)] ^= 8'h01;
    if (flaw == 7 && k.size() > 0) void'(k.pop_back());
    foreach (k[i]) t.push_back(k[i]);
    if (flaw == 6) t.push_back(CH_COLON);
    t.push_back(CH_COLON);
    t.push_back((flaw == 1) ? 8'h20 : CH_TAB);
    t.push_back((flaw == 2) ? 8'h25 : CH_HASH);
    ndig = (flaw == 3) ? $urandom_range(0, NUM_DIGITS - 1) : NUM_DIGITS;
    for (int d = 0; d < ndig; d++) begin
      if (flaw == 4 && d == 2) begin
        do c = CHAR_W'($urandom_range(1, 255)); while (hex_digit(c));
        t.push_back(c);
      end
      t.push_back(rand_hex());
    end
    if (flaw < 0 && $urandom_range(1))
      repeat ($urandom_range(1, 3)) t.push_back(CHAR_W'($urandom_range(1, 255)));
    t.push_back(CH_NL);
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  // Registers come out of reset as an empty key.
  task automatic test_reset_defaults();
    send_str(":\t#A1b2C3");
  endtask

  // Prefixes, first match wins, rejected values, zero byte and short text.
  task automatic test_directed_lines();
    text_t t;
    set_key(64'hA5A5_5A5A_C3C3_3C00 | KEY_TEXT_W'("k"), 1);
    send_str("*k:\t#09afAF");
    send_str("xk:\t#111111\nk: #222222\nk:\t#12g456\nq.k:\t#ABCDEF");
    send_str("k:\t#abcdef\nk:\t#000000");
    send_str("k:\t#123456789z");
    push_str(t, "k:\t#12");
    t.push_back(CH_NUL);
    push_str(t, "\nk:\t#345678");
    send_text(t);
    send_str("k:\t#12");
    t = {};
    t.push_back(CH_NUL);
    send_text(t);
  endtask

  // Empty key: the colon itself must start the line or follow '*' or '.'.
  task automatic test_empty_key();
    set_key({$urandom, $urandom}, 0);
    send_str("a:\t#111111\n*:\t#ABCabc");
    send_str(".:\t#456789");
  endtask

  // All-ones key, all-zero key and a length beyond the key width.
  task automatic test_key_extremes();
    text_t t;
    set_key('1, KEY_MAX_DEF);
    t.push_back(CH_DOT);
    add_key(t);
    push_str(t, ":\t#fFfF09");
    send_text(t);
    set_key('0, 3);
    send_str("abc:\t#123456");
    set_key(KEY_TEXT_W'("HGFEDCBA"), 15);
    send_str("zzABCDEFGH:\t#aaaaaa\nABCDEFGH:\t#bbbbbb");
    set_key({$urandom, $urandom}, 9);
    t = {};
    add_key(t);
    push_str(t, ":\t#CcDdEe");
    send_text(t);
  endtask

  // Hold off results for a long stretch while one-word texts keep coming,
  // so the block backs up and stalls its input.
  task automatic test_backpressure();
    set_key(KEY_TEXT_W'("q"), 1);
    tx_idle_en  = 1'b0;
    rx_hold_req = HOLD_LEN;
    repeat (40) send_word(CHAR_W'($urandom_range(0, 255)), 1'b1);
    tx_idle_en = 1'b1;
  endtask

  // Random texts under several keys; one phase runs with no idling at all.
  task automatic test_random_texts();
    text_t                 t;
    logic [KEY_TEXT_W-1:0] text;
    int                    len;
    int                    start;
    int                    lines;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       len = 0;
        1:       len = 1;
        2:       len = KEY_MAX_DEF;
        3:       len = 15;
        default: len = $urandom_range(2, 7);
      endcase
      text = {$urandom, $urandom};
      for (int j = 0; j < KEY_MAX_DEF && j < len; j++)
        text[CHAR_W*j +: CHAR_W] = rand_key_char();
      set_key(text, len);
      tx_idle_en = (p != 2);
      rx_idle_en = (p != 2);
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) begin
        t = {};
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 3)) t.push_back(CHAR_W'($urandom_range(0, 255)));
        end else begin
          lines = ($urandom_range(3) == 0) ? 2 : 1;
          repeat (lines) build_line(t);
          if ($urandom_range(9) < 3) void'(t.pop_back());
          if ($urandom_range(9) == 0) t.insert($urandom_range(t.size() - 1), CH_NUL);
        end
        if (t.size() > 0) send_text(t);
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_KEY_TEXT;
    cfg_data_i        = '0;
    in_if.valid       = 1'b0;
    in_if.text_byte   = '0;
    in_if.end_of_text = 1'b0;
    out_if.ready      = 1'b0;
    key_chars         = '0;
    key_len           = '0;
    mismatches        = 0;
    words_sent        = 0;
    tx_idle_en        = 1'b1;
    rx_idle_en        = 1'b1;
    rx_hold_req       = 0;
    clear_scan();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_lines();
    test_empty_key();
    test_key_extremes();
    test_backpressure();
    test_random_texts();

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_colours.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/rcl_pkg.sv
rtl/rcl_if.sv
rtl/rcl_cell.sv
rtl/resource_colour_lookup.sv
test/tb.sv
